### hdl/cdaxc_pkg.sv
// Shared types, constants and IEEE double helpers for the complex double AXPY block.
package cdaxc_pkg;

    typedef logic [63:0] dbl_t;

    localparam int FMA_LAT  = 9;    // register stages in one fused multiply-add
    localparam int EXP_W    = 14;   // signed exponent arithmetic width
    localparam int FRM_W    = 272;  // alignment frame width
    localparam int PROD_POS = 110;  // frame bit of the product LSB
    localparam int ADD_MAX  = 218;  // highest addend LSB position in the frame
    localparam int EXT_W    = FRM_W + 53;

    localparam dbl_t       QUIET_BIT = 64'h0008_0000_0000_0000;
    localparam dbl_t       DEF_NAN   = 64'hFFF8_0000_0000_0000;
    localparam logic [62:0] INF_MAG  = 63'h7FF0_0000_0000_0000;

    function automatic logic is_nan(dbl_t v);
        is_nan = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
    endfunction

    function automatic logic is_inf(dbl_t v);
        is_inf = (v[62:0] == INF_MAG);
    endfunction

    function automatic logic is_zero(dbl_t v);
        is_zero = (v[62:0] == 63'd0);
    endfunction

endpackage

### hdl/cdaxc_fma.sv
// Pipelined IEEE double fused multiply-add a*b+c, nearest-even, subnormals kept.
module cdaxc_fma import cdaxc_pkg::*; (
    input  logic clk,
    input  logic adv,
    input  dbl_t a,
    input  dbl_t b,
    input  dbl_t c,
    output dbl_t res
);

    localparam logic signed [EXP_W-1:0] BIAS_ADJ = EXP_W'(1075);
    localparam logic signed [EXP_W-1:0] POS_S    = EXP_W'(PROD_POS);
    localparam logic signed [EXP_W-1:0] MAX_S    = EXP_W'(ADD_MAX);
    localparam logic signed [EXP_W-1:0] EMIN     = -EXP_W'(1074);
    localparam logic signed [EXP_W-1:0] BIAS_MIN = EXP_W'(1074);
    localparam logic signed [EXP_W-1:0] EB_MAX   = EXP_W'(2045);
    localparam logic signed [EXP_W-1:0] MANT_LSB = EXP_W'(52);
    localparam logic [EXP_W-1:0]        R_MAX    = EXP_W'(EXT_W);

    // ---------------- stage 1: unpack, specials, partial products
    logic [52:0] ma, mb, mc;
    logic signed [EXP_W-1:0] ea, eb, ec, ep_c, sa_c;
    logic sp_c, spec_c, cz_c;
    dbl_t sres_c;

    always_comb
    begin
        ma = {(a[62:52] != 11'd0), a[51:0]};
        mb = {(b[62:52] != 11'd0), b[51:0]};
        mc = {(c[62:52] != 11'd0), c[51:0]};
        ea = $signed({3'b0, (a[62:52] == 11'd0) ? 11'd1 : a[62:52]}) - BIAS_ADJ;
        eb = $signed({3'b0, (b[62:52] == 11'd0) ? 11'd1 : b[62:52]}) - BIAS_ADJ;
        ec = $signed({3'b0, (c[62:52] == 11'd0) ? 11'd1 : c[62:52]}) - BIAS_ADJ;
        ep_c = ea + eb;
        sa_c = ec - ep_c + POS_S;
        sp_c = a[63] ^ b[63];
        cz_c = is_zero(c);
        spec_c = 1'b1;
        sres_c = DEF_NAN;
        if (is_nan(a))
        begin
            sres_c = a | QUIET_BIT;
        end
        else if (is_nan(b))
        begin
            sres_c = b | QUIET_BIT;
        end
        else if (is_nan(c))
        begin
            sres_c = c | QUIET_BIT;
        end
        else if (is_inf(a) || is_inf(b))
        begin
            if (is_zero(a) || is_zero(b) || (is_inf(c) && (c[63] != sp_c)))
            begin
                sres_c = DEF_NAN;
            end
            else
            begin
                sres_c = {sp_c, INF_MAG};
            end
        end
        else if (is_inf(c))
        begin
            sres_c = {c[63], INF_MAG};
        end
        else if (is_zero(a) || is_zero(b))
        begin
            sres_c = cz_c ? {sp_c & c[63], 63'd0} : c;
        end
        else
        begin
            spec_c = 1'b0;
        end
    end

    logic [63:0] s1_ll_reg;
    logic [52:0] s1_lh_reg, s1_hl_reg;
    logic [41:0] s1_hh_reg;
    logic signed [EXP_W-1:0] s1_ep_reg, s1_sa_reg;
    logic [52:0] s1_mc_reg;
    logic s1_sp_reg, s1_sc_reg, s1_cz_reg, s1_spec_reg;
    dbl_t s1_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_ll_reg   <= 64'(ma[31:0]) * 64'(mb[31:0]);
            s1_lh_reg   <= 53'(ma[31:0]) * 53'(mb[52:32]);
            s1_hl_reg   <= 53'(ma[52:32]) * 53'(mb[31:0]);
            s1_hh_reg   <= 42'(ma[52:32]) * 42'(mb[52:32]);
            s1_ep_reg   <= ep_c;
            s1_sa_reg   <= sa_c;
            s1_mc_reg   <= mc;
            s1_sp_reg   <= sp_c;
            s1_sc_reg   <= c[63];
            s1_cz_reg   <= cz_c;
            s1_spec_reg <= spec_c;
            s1_sres_reg <= sres_c;
        end
    end

    // ---------------- stage 2: product sum, addend alignment
    logic [105:0] prod_c;
    logic [FRM_W-1:0] add_c;
    logic prep_c;
    logic signed [EXP_W-1:0] f_c;

    always_comb
    begin
        prod_c = 106'(s1_ll_reg) + (106'(s1_lh_reg) << 32) + (106'(s1_hl_reg) << 32)
               + (106'(s1_hh_reg) << 64);
        prep_c = 1'b0;
        f_c    = s1_ep_reg - POS_S;
        if (s1_cz_reg)
        begin
            add_c = '0;
        end
        else if (s1_sa_reg[EXP_W-1])
        begin
            add_c = FRM_W'(1);          // addend far below: sticky only
        end
        else if (s1_sa_reg >= MAX_S)
        begin
            add_c  = FRM_W'(s1_mc_reg) << ADD_MAX;
            prep_c = 1'b1;              // product far below: sticky only
            f_c    = s1_ep_reg + s1_sa_reg - POS_S - MAX_S;   // frame anchored on addend
        end
        else
        begin
            add_c = FRM_W'(s1_mc_reg) << s1_sa_reg[7:0];
        end
    end

    logic [105:0] s2_prod_reg;
    logic [FRM_W-1:0] s2_add_reg;
    logic s2_prep_reg, s2_sp_reg, s2_sc_reg, s2_spec_reg;
    logic signed [EXP_W-1:0] s2_f_reg;
    dbl_t s2_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_prod_reg <= prod_c;
            s2_add_reg  <= add_c;
            s2_prep_reg <= prep_c;
            s2_sp_reg   <= s1_sp_reg;
            s2_sc_reg   <= s1_sc_reg;
            s2_spec_reg <= s1_spec_reg;
            s2_sres_reg <= s1_sres_reg;
            s2_f_reg    <= f_c;
        end
    end

    // ---------------- stage 3: add or subtract in the frame
    logic [FRM_W-1:0] pf_c;
    logic sub_c;
    logic [FRM_W:0] raw_c;

    always_comb
    begin
        pf_c  = s2_prep_reg ? FRM_W'(1) : (FRM_W'(s2_prod_reg) << PROD_POS);
        sub_c = s2_sp_reg ^ s2_sc_reg;
        raw_c = sub_c ? ({1'b0, pf_c} - {1'b0, s2_add_reg})
                      : ({1'b0, pf_c} + {1'b0, s2_add_reg});
    end

    logic [FRM_W:0] s3_raw_reg;
    logic s3_sub_reg, s3_sp_reg, s3_sc_reg, s3_spec_reg;
    logic signed [EXP_W-1:0] s3_f_reg;
    dbl_t s3_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_raw_reg  <= raw_c;
            s3_sub_reg  <= sub_c;
            s3_sp_reg   <= s2_sp_reg;
            s3_sc_reg   <= s2_sc_reg;
            s3_spec_reg <= s2_spec_reg;
            s3_sres_reg <= s2_sres_reg;
            s3_f_reg    <= s2_f_reg;
        end
    end

    // ---------------- stage 4: magnitude and sign
    logic neg_c;
    assign neg_c = s3_sub_reg & s3_raw_reg[FRM_W];

    logic [FRM_W-1:0] s4_mag_reg;
    logic s4_sign_reg, s4_spec_reg;
    logic signed [EXP_W-1:0] s4_f_reg;
    dbl_t s4_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_mag_reg  <= neg_c ? (~s3_raw_reg[FRM_W-1:0] + FRM_W'(1))
                                 : s3_raw_reg[FRM_W-1:0];
            s4_sign_reg <= neg_c ? s3_sc_reg : s3_sp_reg;
            s4_spec_reg <= s3_spec_reg;
            s4_sres_reg <= s3_sres_reg;
            s4_f_reg    <= s3_f_reg;
        end
    end

    // ---------------- stage 5: leading one per 16-bit chunk
    localparam int NCH = FRM_W / 16;
    logic [NCH-1:0] nz_c;
    logic [3:0] pos_c [NCH];

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            nz_c[i]  = |s4_mag_reg[i*16 +: 16];
            pos_c[i] = 4'd0;
            for (int j = 0; j < 16; j++)
            begin
                if (s4_mag_reg[i*16 + j])
                begin
                    pos_c[i] = 4'(j);
                end
            end
        end
    end

    logic [NCH-1:0] s5_nz_reg;
    logic [3:0] s5_pos_reg [NCH];
    logic [FRM_W-1:0] s5_mag_reg;
    logic s5_sign_reg, s5_spec_reg;
    logic signed [EXP_W-1:0] s5_f_reg;
    dbl_t s5_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_nz_reg   <= nz_c;
            s5_pos_reg  <= pos_c;
            s5_mag_reg  <= s4_mag_reg;
            s5_sign_reg <= s4_sign_reg;
            s5_spec_reg <= s4_spec_reg;
            s5_sres_reg <= s4_sres_reg;
            s5_f_reg    <= s4_f_reg;
        end
    end

    // ---------------- stage 6: leading one of the whole frame
    logic [8:0] k_c;

    always_comb
    begin
        k_c = 9'd0;
        for (int i = 0; i < NCH; i++)
        begin
            if (s5_nz_reg[i])
            begin
                k_c = {5'(i), s5_pos_reg[i]};
            end
        end
    end

    logic [8:0] s6_k_reg;
    logic s6_zr_reg;
    logic [FRM_W-1:0] s6_mag_reg;
    logic s6_sign_reg, s6_spec_reg;
    logic signed [EXP_W-1:0] s6_f_reg;
    dbl_t s6_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_k_reg    <= k_c;
            s6_zr_reg   <= ~|s5_nz_reg;
            s6_mag_reg  <= s5_mag_reg;
            s6_sign_reg <= s5_sign_reg;
            s6_spec_reg <= s5_spec_reg;
            s6_sres_reg <= s5_sres_reg;
            s6_f_reg    <= s5_f_reg;
        end
    end

    // ---------------- stage 7: result exponent and shift amount
    logic signed [EXP_W-1:0] e_c, ecl_c, adj_c;
    logic [EXP_W-1:0] r_c;

    always_comb
    begin
        e_c = s6_f_reg + $signed({5'b0, s6_k_reg}) - MANT_LSB;
        if (e_c < EMIN)
        begin
            adj_c = EMIN - e_c;     // subnormal result: extra right shift
            ecl_c = EMIN;
        end
        else
        begin
            adj_c = '0;
            ecl_c = e_c;
        end
        r_c = EXP_W'(s6_k_reg) + adj_c;
        if (r_c > R_MAX)
        begin
            r_c = R_MAX;
        end
    end

    logic [8:0] s7_r_reg;
    logic signed [EXP_W-1:0] s7_e_reg;
    logic s7_zr_reg;
    logic [FRM_W-1:0] s7_mag_reg;
    logic s7_sign_reg, s7_spec_reg;
    dbl_t s7_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s7_r_reg    <= r_c[8:0];
            s7_e_reg    <= ecl_c;
            s7_zr_reg   <= s6_zr_reg;
            s7_mag_reg  <= s6_mag_reg;
            s7_sign_reg <= s6_sign_reg;
            s7_spec_reg <= s6_spec_reg;
            s7_sres_reg <= s6_sres_reg;
        end
    end

    // ---------------- stage 8: extract mantissa, guard, sticky
    logic [EXT_W-1:0] ext_c, sh_c, lowm_c;

    always_comb
    begin
        ext_c  = {s7_mag_reg, 53'd0};
        sh_c   = ext_c >> s7_r_reg;
        lowm_c = ~({EXT_W{1'b1}} << s7_r_reg);
    end

    logic [52:0] s8_m_reg;
    logic s8_g_reg, s8_st_reg, s8_zr_reg, s8_sign_reg, s8_spec_reg;
    logic signed [EXP_W-1:0] s8_e_reg;
    dbl_t s8_sres_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s8_m_reg    <= sh_c[53:1];
            s8_g_reg    <= sh_c[0];
            s8_st_reg   <= |(ext_c & lowm_c);
            s8_zr_reg   <= s7_zr_reg;
            s8_sign_reg <= s7_sign_reg;
            s8_spec_reg <= s7_spec_reg;
            s8_sres_reg <= s7_sres_reg;
            s8_e_reg    <= s7_e_reg;
        end
    end

    // ---------------- stage 9: round and pack
    logic [53:0] mr_c;
    logic [52:0] mf_c;
    logic signed [EXP_W-1:0] eb_c;
    dbl_t pk_c;

    always_comb
    begin
        mr_c = {1'b0, s8_m_reg} + 54'(s8_g_reg & (s8_st_reg | s8_m_reg[0]));
        eb_c = s8_e_reg + BIAS_MIN;
        if (mr_c[53])
        begin
            mf_c = mr_c[53:1];
            eb_c = eb_c + EXP_W'(1);
        end
        else
        begin
            mf_c = mr_c[52:0];
        end
        if (s8_spec_reg)
        begin
            pk_c = s8_sres_reg;
        end
        else if (s8_zr_reg)
        begin
            pk_c = '0;
        end
        else if (eb_c > EB_MAX)
        begin
            pk_c = {s8_sign_reg, INF_MAG};
        end
        else
        begin
            // hidden bit carries into the exponent field
            pk_c = {s8_sign_reg, {eb_c[10:0], 52'd0} + {10'd0, mf_c}};
        end
    end

    dbl_t res_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= pk_c;
        end
    end

    assign res = res_reg;

endmodule

### hdl/complex_double_axpy_conj.sv
// Top level of the complex double AXPY stream unit: sum = y + alpha * x or y + alpha * conj(x).
//
// One complex element per cycle in, one per cycle out, while the output side keeps
// up. Each component of the result goes through two chained fused multiply-adds,
// each a 9-stage pipeline, so an item passes through both in turn before it leaves.
// The whole pipeline advances together; while a finished item waits on
// m_tready, everything holds and s_tready is low, so nothing is lost or doubled.
// Rounding is nearest-even with subnormals kept. Alpha and the conjugate
// choice are to be written on the cfg channel only while the stream is idle; the
// block itself does not enforce this. cfg_ready is always high and writes to index 3 are dropped.
module complex_double_axpy_conj import cdaxc_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [255:0] s_tdata,   // x_real, x_imag, y_real, y_imag (64 each)
    input  logic         s_tlast,   // last_in
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // sum_real, sum_imag (64 each)
    output logic         m_tlast,   // last_out
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    localparam logic [1:0] REG_ALPHA_RE = 2'd0;
    localparam logic [1:0] REG_ALPHA_IM = 2'd1;
    localparam logic [1:0] REG_CONJ     = 2'd2;
    localparam int PIPE_LEN = 2 * FMA_LAT;

    // (+0 * +0) +/- v as the sign fix-up: NaN quieted, zero becomes +0
    function automatic dbl_t sign_fix(dbl_t v, logic neg);
        if (is_nan(v))
        begin
            sign_fix = v | QUIET_BIT;
        end
        else if (is_zero(v))
        begin
            sign_fix = '0;
        end
        else
        begin
            sign_fix = {v[63] ^ neg, v[62:0]};
        end
    endfunction

    // ---------------- configuration registers
    dbl_t alpha_re_reg, alpha_im_reg;
    logic conj_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_re_reg <= '0;
            alpha_im_reg <= '0;
            conj_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ALPHA_RE: alpha_re_reg <= cfg_data;
                REG_ALPHA_IM: alpha_im_reg <= cfg_data;
                REG_CONJ:     conj_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    // signed alpha parts per output component
    dbl_t ar_re, ar_im, ai_re, ai_im;

    always_comb
    begin
        if (conj_reg)
        begin
            ar_re = sign_fix(alpha_re_reg, 1'b0);
            ar_im = sign_fix(alpha_re_reg, 1'b1);
            ai_re = alpha_im_reg;
            ai_im = alpha_im_reg;
        end
        else
        begin
            ar_re = alpha_re_reg;
            ar_im = alpha_re_reg;
            ai_re = sign_fix(alpha_im_reg, 1'b1);
            ai_im = sign_fix(alpha_im_reg, 1'b0);
        end
    end

    // ---------------- pipeline control: one enable for all stages
    logic adv;
    logic [PIPE_LEN-1:0] vld_reg;
    logic [PIPE_LEN-1:0] last_reg;

    assign adv      = ~vld_reg[PIPE_LEN-1] | m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            last_reg <= {last_reg[PIPE_LEN-2:0], s_tlast};
        end
    end

    // x parts wait for the first multiply-add to finish
    dbl_t xr_dly_reg [FMA_LAT];
    dbl_t xi_dly_reg [FMA_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xr_dly_reg[0] <= s_tdata[63:0];
            xi_dly_reg[0] <= s_tdata[127:64];
            for (int i = 1; i < FMA_LAT; i++)
            begin
                xr_dly_reg[i] <= xr_dly_reg[i-1];
                xi_dly_reg[i] <= xi_dly_reg[i-1];
            end
        end
    end

    // ---------------- arithmetic
    dbl_t re_mid, im_mid, re_out, im_out;

    cdaxc_fma u_re1 (
        .clk (clk), .adv (adv),
        .a   (ar_re), .b (s_tdata[63:0]), .c (s_tdata[191:128]),
        .res (re_mid)
    );

    cdaxc_fma u_im1 (
        .clk (clk), .adv (adv),
        .a   (ar_im), .b (s_tdata[127:64]), .c (s_tdata[255:192]),
        .res (im_mid)
    );

    cdaxc_fma u_re2 (
        .clk (clk), .adv (adv),
        .a   (ai_re), .b (xi_dly_reg[FMA_LAT-1]), .c (re_mid),
        .res (re_out)
    );

    cdaxc_fma u_im2 (
        .clk (clk), .adv (adv),
        .a   (ai_im), .b (xr_dly_reg[FMA_LAT-1]), .c (im_mid),
        .res (im_out)
    );

    assign m_tvalid = vld_reg[PIPE_LEN-1];
    assign m_tdata  = {im_out, re_out};
    assign m_tlast  = last_reg[PIPE_LEN-1];

`ifndef NO_ASSERTIONS
    // input side stalls only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // an accepted item enters the first stage; items advance one stage per enabled cycle
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted item missing from first stage");

    // a first-stage item stays valid while the pipeline is frozen
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        (!adv && vld_reg[0]) |=> vld_reg[0])
        else $error("stage valid lost during stall");
`endif

endmodule

### test/tb_complex_double_axpy_conj.sv
// Self-checking testbench for the complex double AXPY stream unit.
module tb_complex_double_axpy_conj import cdaxc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // configuration register indexes
    localparam logic [1:0] REG_ALPHA_RE = 2'd0;
    localparam logic [1:0] REG_ALPHA_IM = 2'd1;
    localparam logic [1:0] REG_CONJ     = 2'd2;
    localparam logic [1:0] REG_UNUSED   = 2'd3;   // writes here are dropped

    localparam dbl_t POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam dbl_t NEG_INF  = 64'hFFF0_0000_0000_0000;
    localparam dbl_t NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam dbl_t ONE      = 64'h3FF0_0000_0000_0000;
    localparam dbl_t MAX_DBL  = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam dbl_t MIN_SUB  = 64'h0000_0000_0000_0001;
    localparam dbl_t MAX_SUB  = 64'h000F_FFFF_FFFF_FFFF;
    localparam dbl_t MIN_NORM = 64'h0010_0000_0000_0000;
    localparam dbl_t SNAN     = 64'h7FF0_0000_0000_0001;
    localparam dbl_t QNAN_NEG = 64'hFFF8_0000_0000_BEEF;
    localparam int   RX_HOLD  = 80;
    localparam int   DRAIN    = 40;

    typedef struct packed {
        dbl_t re;
        dbl_t im;
        logic last;
    } sum_item_t;

    // Scoreboard: holds alpha/conj shadow, predicts each sum, checks results in order.
    class axpy_scoreboard;
        dbl_t      alpha_re;
        dbl_t      alpha_im;
        bit        conj;
        sum_item_t sums_due[$];
        int        errors;

        function new();
            alpha_re = '0;
            alpha_im = '0;
            conj     = 1'b0;
            errors   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] val);
            case (idx)
                REG_ALPHA_RE: alpha_re = val;
                REG_ALPHA_IM: alpha_im = val;
                REG_CONJ:     conj     = val[0];
                default: ;
            endcase
        endfunction

        function bit nan_f(dbl_t v);
            return v[62:52] == 11'h7FF && v[51:0] != 0;
        endfunction

        function bit inf_f(dbl_t v);
            return v[62:0] == POS_INF[62:0];
        endfunction

        function bit zero_f(dbl_t v);
            return v[62:0] == 0;
        endfunction

        function int top_bit(logic [127:0] r);
            for (int i = 127; i >= 0; i--)
                if (r[i]) return i;
            return -1;
        endfunction

        // any bit below position n set
        function bit low_set(logic [127:0] r, int n);
            if (n <= 0) return 0;
            if (n >= 128) return r != 0;
            return (r & ((128'd1 << n) - 1)) != 0;
        endfunction

        // mantissa with hidden bit at 52, value = m * 2^exp
        function int split(dbl_t v, output logic [63:0] m);
            int e;
            m = {12'd0, v[51:0]};
            if (v[62:52] == 0) begin
                e = -1074;
                while (m < 64'h0010_0000_0000_0000) begin
                    m = m << 1;
                    e--;
                end
            end else begin
                m[52] = 1'b1;
                e = int'(v[62:52]) - 1075;
            end
            return e;
        endfunction

        // round r * 2^er to nearest-even double of sign s
        function dbl_t round_pack(bit s, logic [127:0] r, int er);
            int          k;
            int          sh;
            int          e;
            logic [127:0] q;
            logic [63:0] m;
            bit          rnd;
            bit          st;
            k  = top_bit(r);
            sh = k - 52;
            e  = er + sh;
            if (e < -1074) begin
                sh += -1074 - e;
                e = -1074;
            end
            if (sh <= 0) begin
                m = r[63:0] << (-sh);
            end else begin
                q   = (sh - 1 >= 128) ? 128'd0 : r >> (sh - 1);
                rnd = q[0];
                st  = low_set(r, sh - 1);
                m   = {1'b0, q[63:1]};
                if (rnd && (st || m[0])) m++;
            end
            if (m == 64'h0020_0000_0000_0000) begin
                m = m >> 1;
                e++;
            end
            if (e + 1074 > 2045) return {s, POS_INF[62:0]};
            return {s, 63'd0} | ((64'(e + 1074) << 52) + m);
        endfunction

        // a * b + c (c negated when neg_c), single rounding
        function dbl_t fused(dbl_t a, dbl_t b, dbl_t c, bit neg_c);
            bit           sc;
            bit           sp;
            bit           sbig;
            logic [63:0]  ma;
            logic [63:0]  mb;
            logic [63:0]  mc;
            int           ea;
            int           eb;
            int           ec;
            int           ep;
            int           k;
            int           d;
            int           ebig;
            bit           lz;
            logic [127:0] p;
            logic [127:0] cc;
            logic [127:0] big;
            logic [127:0] sml;
            logic [127:0] r;
            if (nan_f(a)) return a | QUIET_BIT;
            if (nan_f(b)) return b | QUIET_BIT;
            if (nan_f(c)) return c | QUIET_BIT;
            sc = c[63] ^ neg_c;
            sp = a[63] ^ b[63];
            if (inf_f(a) || inf_f(b)) begin
                if (zero_f(a) || zero_f(b)) return DEF_NAN;
                if (inf_f(c) && sc != sp) return DEF_NAN;
                return {sp, POS_INF[62:0]};
            end
            if (inf_f(c)) return {sc, POS_INF[62:0]};
            if (zero_f(a) || zero_f(b)) begin
                if (zero_f(c)) return {sp & sc, 63'd0};
                return {sc, c[62:0]};
            end
            ea = split(a, ma);
            eb = split(b, mb);
            p  = {64'd0, ma} * {64'd0, mb};
            k  = top_bit(p);
            p  = p << (125 - k);
            ep = ea + eb - (125 - k);
            if (zero_f(c)) return round_pack(sp, p, ep);
            ec = split(c, mc) - 73;
            cc = {64'd0, mc} << 73;
            if (ep > ec || (ep == ec && p >= cc)) begin
                big = p; sbig = sp; ebig = ep; sml = cc; d = ep - ec;
            end else begin
                big = cc; sbig = sc; ebig = ec; sml = p; d = ec - ep;
            end
            lz  = low_set(sml, d);
            sml = (d >= 128) ? 128'd0 : sml >> d;
            sml[0] = sml[0] | lz;
            if (sp == sc) begin
                r = big + sml;
            end else begin
                r = big - sml;
                if (r == 0) return '0;
            end
            return round_pack(sbig, r, ebig);
        endfunction

        function void note_input(dbl_t xr, dbl_t xi, dbl_t yr, dbl_t yi, logic last);
            dbl_t      a_rr;
            dbl_t      a_ri;
            dbl_t      a_ir;
            dbl_t      a_ii;
            sum_item_t s;
            if (!conj) begin
                a_rr = alpha_re;
                a_ri = alpha_re;
                a_ir = fused('0, '0, alpha_im, 1'b1);
                a_ii = fused('0, '0, alpha_im, 1'b0);
            end else begin
                a_rr = fused('0, '0, alpha_re, 1'b0);
                a_ri = fused('0, '0, alpha_re, 1'b1);
                a_ir = alpha_im;
                a_ii = alpha_im;
            end
            s.re   = fused(a_ir, xi, fused(a_rr, xr, yr, 1'b0), 1'b0);
            s.im   = fused(a_ii, xr, fused(a_ri, xi, yi, 1'b0), 1'b0);
            s.last = last;
            sums_due.push_back(s);
        endfunction

        function void check_sum(sum_item_t got);
            sum_item_t want;
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected result re=%h im=%h last=%b",
                         $realtime, got.re, got.im, got.last);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            if (got.re !== want.re) begin
                $display("%0t: sum_real expected %h actual %h", $realtime, want.re, got.re);
                errors++;
            end
            if (got.im !== want.im) begin
                $display("%0t: sum_imag expected %h actual %h", $realtime, want.im, got.im);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_out expected %b actual %b", $realtime, want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;    // x_real, x_imag, y_real, y_imag
    logic         s_tlast;    // last_in
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // sum_real, sum_imag
    logic         m_tlast;    // last_out
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [63:0]  cfg_data;

    axpy_scoreboard sb;
    bit             calm;       // no random idling on either side while set
    bit             hold_rx;    // request a long receiver hold-off

    complex_double_axpy_conj dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #3ms;
        $display("Test completed with failures");
        $finish;
    end

    // random double: mostly finite values of similar magnitude so the adds
    // cancel and round, plus raw bit patterns and the special encodings
    function automatic dbl_t pick_dbl();
        dbl_t v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       v = v;
            1:       case ($urandom_range(0, 6))
                         0: v = '0;
                         1: v = NEG_ZERO;
                         2: v = POS_INF;
                         3: v = NEG_INF;
                         4: v = {v[63], 11'h7FF, v[51:1], 1'b1};
                         5: v = {v[63], 11'd0, v[51:0]};
                         default: v = {v[63], MAX_DBL[62:0]};
                     endcase
            2:       v[62:52] = 11'($urandom_range(1, 60));      // near subnormal range
            3:       v[62:52] = 11'($urandom_range(1990, 2046)); // near overflow
            default: v[62:52] = 11'($urandom_range(1015, 1035));
        endcase
        return v;
    endfunction

    task automatic cfg_write(logic [1:0] idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    // wait for the pipeline to empty before touching alpha or conj
    task automatic drain_pipe();
        while (sb.sums_due.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic send_elem(dbl_t xr, dbl_t xi, dbl_t yr, dbl_t yi, logic last);
        if (!calm && $urandom_range(0, 99) < 37) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {yi, yr, xi, xr};
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_input(xr, xi, yr, yi, last);
    endtask

    task automatic send_rand(int n);
        for (int i = 0; i < n; i++)
            send_elem(pick_dbl(), pick_dbl(), pick_dbl(), pick_dbl(), 1'($urandom));
        s_tvalid <= 1'b0;
    endtask

    // result side: random back-pressure, one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_sum('{m_tdata[63:0], m_tdata[127:64], m_tlast});
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD - 1) @(posedge clk);
                hold_rx = 1'b0;
                m_tready <= 1'b1;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 37);
            end
        end
    end

    initial
    begin
        sb        = new();
        calm      = 1'b0;
        hold_rx   = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ALPHA_RE;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset config (alpha = 0) with special x and y
        send_elem(ONE, NEG_ZERO, MIN_SUB, NEG_ZERO, 1'b1);
        send_elem(POS_INF, ONE, ONE, ONE, 1'b0);
        send_elem(SNAN, ONE, ONE, QNAN_NEG, 1'b0);
        s_tvalid <= 1'b0;
        drain_pipe();

        // alpha = 1 + 0.5i, plain x
        cfg_write(REG_ALPHA_RE, ONE);
        cfg_write(REG_ALPHA_IM, 64'h3FE0_0000_0000_0000);
        cfg_write(REG_CONJ, 64'hFFFF_FFFF_FFFF_FFFE);   // only bit 0 counts
        send_elem('0, NEG_ZERO, NEG_ZERO, '0, 1'b0);
        send_elem(MAX_DBL, MAX_DBL, MAX_DBL, MAX_DBL, 1'b1);    // overflow
        send_elem(MIN_SUB, MAX_SUB, MIN_NORM, {1'b1, MIN_SUB[62:0]}, 1'b0);
        send_elem(POS_INF, NEG_INF, NEG_INF, POS_INF, 1'b0);    // inf - inf
        send_elem(ONE, {1'b1, ONE[62:0]}, {1'b1, ONE[62:0]}, 64'hBFE0_0000_0000_0000, 1'b0);
        send_elem(SNAN, QNAN_NEG, SNAN, QNAN_NEG, 1'b1);
        send_elem(ONE, SNAN, QNAN_NEG, ONE, 1'b0);
        send_elem(ONE, ONE, 64'h3CA0_0000_0000_0000, 64'h3CA0_0000_0000_0001, 1'b0);
        send_elem('1, '1, '1, '1, 1'b1);
        s_tvalid <= 1'b0;
        drain_pipe();

        // conjugate, negative alpha; receiver holds off while items keep coming
        cfg_write(REG_ALPHA_RE, 64'hC004_0000_0000_0000);
        cfg_write(REG_ALPHA_IM, 64'h4008_0000_0000_0000);
        cfg_write(REG_CONJ, 64'd1);
        cfg_write(REG_UNUSED, ONE);
        send_elem(ONE, ONE, '0, '0, 1'b0);
        send_elem('0, '0, '0, '0, 1'b1);
        send_elem(MIN_SUB, MIN_SUB, MIN_SUB, MIN_SUB, 1'b0);
        calm    = 1'b1;
        hold_rx = 1'b1;
        send_rand(40);
        calm = 1'b0;
        send_rand(60);
        drain_pipe();

        // signed zeros and conjugate: zero products meet zero addends
        cfg_write(REG_ALPHA_RE, NEG_ZERO);
        cfg_write(REG_ALPHA_IM, '0);
        send_rand(40);
        s_tvalid <= 1'b0;
        while (sb.sums_due.size() != 0) @(posedge clk);   // sender pause until empty
        send_rand(40);
        drain_pipe();

        // NaN and infinite alpha
        cfg_write(REG_ALPHA_RE, QNAN_NEG);
        cfg_write(REG_ALPHA_IM, NEG_INF);
        cfg_write(REG_CONJ, 64'd0);
        send_rand(60);
        drain_pipe();
        cfg_write(REG_ALPHA_RE, POS_INF);
        cfg_write(REG_ALPHA_IM, SNAN);
        cfg_write(REG_CONJ, 64'd1);
        send_rand(40);
        drain_pipe();

        // extremes of magnitude
        cfg_write(REG_ALPHA_RE, MAX_DBL);
        cfg_write(REG_ALPHA_IM, {1'b1, MIN_SUB[62:0]});
        cfg_write(REG_CONJ, 64'd0);
        send_rand(50);
        drain_pipe();

        // random alphas of ordinary magnitude
        for (int ph = 0; ph < 3; ph++)
        begin
            cfg_write(REG_ALPHA_RE, {1'($urandom), 11'($urandom_range(1015, 1035)),
                                     20'($urandom), $urandom});
            cfg_write(REG_ALPHA_IM, {1'($urandom), 11'($urandom_range(1015, 1035)),
                                     20'($urandom), $urandom});
            cfg_write(REG_CONJ, 64'($urandom));
            calm = (ph == 1);
            send_rand(50);
            drain_pipe();
        end
        calm = 1'b0;

        // alpha all ones, then back to zero
        cfg_write(REG_ALPHA_RE, '1);
        cfg_write(REG_ALPHA_IM, '1);
        send_rand(20);
        drain_pipe();
        cfg_write(REG_ALPHA_RE, '0);
        cfg_write(REG_ALPHA_IM, '0);
        send_rand(20);
        drain_pipe();

        if (sb.errors == 0 && sb.sums_due.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
